### rtl/fmbs_pkg.sv
// ----------------------------------------------------------------------------
// fmbs_pkg
// Shared constants, codes and types for the binary BWT backward search block.
// ----------------------------------------------------------------------------
package fmbs_pkg;

	// store depths and widths
	localparam int TEXT_MAX   = 4096;
	localparam int SAMPLE_MAX = 4096;
	localparam int ADDR_W     = 12;   // address / text position width
	localparam int ROW_W      = 13;   // row bound width (holds TEXT_MAX)
	localparam int CUR_W      = 14;   // walk row and divider width
	localparam int CFG_IDX_W  = 3;

	// input commands
	typedef enum logic [1:0] {
		CMD_WR_BWT = 2'd0,
		CMD_WR_SA  = 2'd1,
		CMD_PAT    = 2'd2,
		CMD_LOCATE = 2'd3
	} cmd_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SENTINEL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ZERO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ONE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARSE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 3'd5;

	// result kinds and status codes
	localparam logic KIND_COUNT  = 1'b0;
	localparam logic KIND_LOCATE = 1'b1;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NO_ROWS = 2'd1;
	localparam logic [1:0] STAT_WALK    = 2'd2;

	// sequencer states
	typedef enum logic [12:0] {
		ST_IDLE     = 13'b0000000000001,
		ST_RSWEEP_A = 13'b0000000000010,
		ST_RSWEEP_D = 13'b0000000000100,
		ST_PAT_FIN  = 13'b0000000001000,
		ST_LOC_SA_D = 13'b0000000010000,
		ST_WALK_DIV = 13'b0000000100000,
		ST_WALK_CHK = 13'b0000001000000,
		ST_LF_RD    = 13'b0000010000000,
		ST_LF_C     = 13'b0000100000000,
		ST_STEP_CHK = 13'b0001000000000,
		ST_FIN_D    = 13'b0010000000000,
		ST_FIN_DIV  = 13'b0100000000000,
		ST_EMIT     = 13'b1000000000000
	} state_t;

endpackage

### rtl/fm_index_backward_search.sv
// ----------------------------------------------------------------------------
// fm_index_backward_search
// Backward search, count and locate over a binary BWT with sampled SA.
// ----------------------------------------------------------------------------
// A pattern bit sweeps the BWT store from row zero up to the high bound,
// each row in an address and a count phase, and gets both ranks in one
// pass. A direct locate reads the sampled SA at the next row. A sparse locate
// runs, per LF step, a divide for the sample test plus a rank sweep up to the
// current row, then a final SA read and a modulo by n; the walk ends with a
// walk status once its step count exceeds n. The BWT store has one read port
// and the divider is shared. No item is taken while one is at work.
module fm_index_backward_search
	import fmbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ROW_W-1:0]     cfg_data,
	// input items
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           cmd,
	input  logic [ADDR_W-1:0]    address,
	input  logic                 bit_value,
	input  logic [ADDR_W-1:0]    sa_value,
	input  logic                 pattern_start,
	input  logic                 pattern_end,
	// result items
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 result_kind,
	output logic [ROW_W-1:0]     match_count,
	output logic [ROW_W-1:0]     interval_start,
	output logic [ADDR_W-1:0]    text_position,
	output logic                 last_position,
	output logic [1:0]           status
);

	// configuration registers
	logic [ROW_W-1:0]  text_length_q, base_zero_q, base_one_q, sample_rate_q;
	logic [ADDR_W-1:0] sentinel_q;
	logic              sparse_q;

	// search state
	state_t            state_q;
	logic [ROW_W-1:0]  range_low_q, range_high_q, next_row_q;
	logic              rc_q, pend_q, rank_lf_q;
	logic [ROW_W-1:0]  plo_q, phi_q, r_q, cnt_q, cnt_lo_q;
	logic [CUR_W-1:0]  cur_q;
	logic [ROW_W-1:0]  steps_q;
	logic [CUR_W-1:0]  dq_q, dr_q;
	logic [3:0]        dcnt_q;

	// pending result
	logic              res_kind_q, res_last_q;
	logic [ROW_W-1:0]  res_count_q, res_start_q;
	logic [ADDR_W-1:0] res_pos_q;
	logic [1:0]        res_status_q;

	// output register
	logic              out_valid_q;

	// memories
	logic              bwt_we, bwt_rdata;
	logic [ADDR_W-1:0] bwt_raddr, sa_raddr;
	logic              sa_we;
	logic [ADDR_W-1:0] sa_rdata;

	logic in_acc;
	logic emit_go;
	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign bwt_we   = in_acc && (cmd_t'(cmd) == CMD_WR_BWT);
	assign sa_we    = in_acc && (cmd_t'(cmd) == CMD_WR_SA);
	// result moves into the output register when that register is free
	assign emit_go  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	fmbs_ram #(.WIDTH(1), .DEPTH(TEXT_MAX)) u_bwt (
		.clk   (clk),
		.we    (bwt_we),
		.waddr (address),
		.wdata (bit_value),
		.raddr (bwt_raddr),
		.rdata (bwt_rdata)
	);

	fmbs_ram #(.WIDTH(ADDR_W), .DEPTH(SAMPLE_MAX)) u_sa (
		.clk   (clk),
		.we    (sa_we),
		.waddr (address),
		.wdata (sa_value),
		.raddr (sa_raddr),
		.rdata (sa_rdata)
	);

	// effective length and base of the current symbol
	logic [ROW_W-1:0] n_eff, base_c;
	assign n_eff  = (text_length_q > ROW_W'(TEXT_MAX)) ? ROW_W'(TEXT_MAX) : text_length_q;
	assign base_c = rc_q ? base_one_q : base_zero_q;

	// read address selection
	always_comb begin
		bwt_raddr = r_q[ADDR_W-1:0];
		if (state_q == ST_LF_RD) begin
			bwt_raddr = cur_q[ADDR_W-1:0];
		end
		sa_raddr = next_row_q[ADDR_W-1:0];
		if (state_q == ST_WALK_CHK) begin
			sa_raddr = dq_q[ADDR_W-1:0];
		end
	end

	// shared restoring divider, one quotient bit per cycle
	logic [ROW_W-1:0] div_den;
	logic [CUR_W-1:0] div_t, div_r_nx, div_q_nx;
	logic             div_ge;
	assign div_den  = (state_q == ST_FIN_DIV) ? n_eff : sample_rate_q;
	assign div_t    = {dr_q[CUR_W-2:0], dq_q[CUR_W-1]};
	assign div_ge   = div_t >= {1'b0, div_den};
	assign div_r_nx = div_ge ? (div_t - {1'b0, div_den}) : div_t;
	assign div_q_nx = {dq_q[CUR_W-2:0], div_ge};

	// pattern step arithmetic
	logic [ROW_W-1:0] in_lo, in_hi;
	logic [CUR_W-1:0] new_lo_w, new_hi_w, lf_next;
	logic [ROW_W-1:0] new_lo, new_hi;
	assign in_lo    = pattern_start ? '0 : range_low_q;
	assign in_hi    = pattern_start ? n_eff : range_high_q;
	assign new_lo_w = {1'b0, base_c} + {1'b0, cnt_lo_q};
	assign new_hi_w = {1'b0, base_c} + {1'b0, cnt_q};
	assign new_lo   = (new_lo_w > {1'b0, n_eff}) ? n_eff : new_lo_w[ROW_W-1:0];
	assign new_hi   = (new_hi_w > {1'b0, n_eff}) ? n_eff : new_hi_w[ROW_W-1:0];
	assign lf_next  = new_hi_w;

	// locate helpers
	logic [ROW_W-1:0] row_inc, cur_lim;
	logic [CUR_W-1:0] fin_sum;
	logic [ADDR_W-1:0] fin_sa;
	logic             loc_last;
	assign row_inc  = next_row_q + ROW_W'(1);
	assign loc_last = (row_inc == range_high_q);
	assign cur_lim  = (cur_q > {1'b0, n_eff}) ? n_eff : cur_q[ROW_W-1:0];
	assign fin_sa   = (dq_q < CUR_W'(SAMPLE_MAX)) ? sa_rdata : '0;
	assign fin_sum  = {2'b00, fin_sa} + {1'b0, steps_q};

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_length_q <= ROW_W'(1);
			sentinel_q    <= '0;
			base_zero_q   <= ROW_W'(1);
			base_one_q    <= ROW_W'(1);
			sparse_q      <= 1'b0;
			sample_rate_q <= ROW_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_TEXT_LENGTH: text_length_q <= cfg_data;
				CFG_SENTINEL:    sentinel_q    <= cfg_data[ADDR_W-1:0];
				CFG_BASE_ZERO:   base_zero_q   <= cfg_data;
				CFG_BASE_ONE:    base_one_q    <= cfg_data;
				CFG_SPARSE:      sparse_q      <= cfg_data[0];
				CFG_SAMPLE_RATE: sample_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// output valid: set on handoff, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			range_low_q  <= '0;
			range_high_q <= '0;
			next_row_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (cmd_t'(cmd))
							CMD_PAT: begin
								rc_q   <= bit_value;
								pend_q <= pattern_end;
								if (in_lo < in_hi) begin
									plo_q     <= (in_lo > n_eff) ? n_eff : in_lo;
									phi_q     <= (in_hi > n_eff) ? n_eff : in_hi;
									r_q       <= '0;
									cnt_q     <= '0;
									rank_lf_q <= 1'b0;
									state_q   <= ST_RSWEEP_A;
								end else begin
									range_low_q  <= '0;
									range_high_q <= '0;
									next_row_q   <= '0;
									res_kind_q   <= KIND_COUNT;
									res_count_q  <= '0;
									res_start_q  <= '0;
									res_pos_q    <= '0;
									res_last_q   <= 1'b0;
									res_status_q <= STAT_OK;
									state_q      <= pattern_end ? ST_EMIT : ST_IDLE;
								end
							end
							CMD_LOCATE: begin
								res_kind_q  <= KIND_LOCATE;
								res_count_q <= (range_high_q > range_low_q) ?
									(range_high_q - range_low_q) : '0;
								res_start_q <= range_low_q;
								if (next_row_q >= range_high_q) begin
									res_pos_q    <= '0;
									res_last_q   <= 1'b0;
									res_status_q <= STAT_NO_ROWS;
									state_q      <= ST_EMIT;
								end else if (!sparse_q || sample_rate_q <= ROW_W'(1)) begin
									state_q <= ST_LOC_SA_D;
								end else begin
									cur_q   <= {1'b0, next_row_q};
									steps_q <= '0;
									dq_q    <= {1'b0, next_row_q};
									dr_q    <= '0;
									dcnt_q  <= '0;
									state_q <= ST_WALK_DIV;
								end
							end
							default: ;
						endcase
					end
				end

				// rank sweep: address phase
				ST_RSWEEP_A: begin
					if (r_q == plo_q) begin
						cnt_lo_q <= cnt_q;
					end
					if (r_q >= phi_q) begin
						if (rank_lf_q) begin
							cur_q   <= lf_next;
							steps_q <= steps_q + ROW_W'(1);
							state_q <= ST_STEP_CHK;
						end else begin
							state_q <= ST_PAT_FIN;
						end
					end else begin
						state_q <= ST_RSWEEP_D;
					end
				end

				// rank sweep: count phase
				ST_RSWEEP_D: begin
					if (r_q[ADDR_W-1:0] != sentinel_q && bwt_rdata == rc_q) begin
						cnt_q <= cnt_q + ROW_W'(1);
					end
					r_q     <= r_q + ROW_W'(1);
					state_q <= ST_RSWEEP_A;
				end

				// new interval from the two ranks
				ST_PAT_FIN: begin
					res_kind_q   <= KIND_COUNT;
					res_pos_q    <= '0;
					res_last_q   <= 1'b0;
					res_status_q <= STAT_OK;
					if (new_lo >= new_hi) begin
						range_low_q  <= '0;
						range_high_q <= '0;
						next_row_q   <= '0;
						res_count_q  <= '0;
						res_start_q  <= '0;
					end else begin
						range_low_q  <= new_lo;
						range_high_q <= new_hi;
						next_row_q   <= new_lo;
						res_count_q  <= new_hi - new_lo;
						res_start_q  <= new_lo;
					end
					state_q <= pend_q ? ST_EMIT : ST_IDLE;
				end

				// direct SA lookup
				ST_LOC_SA_D: begin
					res_pos_q    <= sa_rdata;
					res_last_q   <= loc_last;
					res_status_q <= STAT_OK;
					next_row_q   <= row_inc;
					state_q      <= ST_EMIT;
				end

				// row mod sample rate
				ST_WALK_DIV: begin
					dq_q   <= div_q_nx;
					dr_q   <= div_r_nx;
					dcnt_q <= dcnt_q + 4'd1;
					if (dcnt_q == 4'(CUR_W - 1)) begin
						state_q <= ST_WALK_CHK;
					end
				end

				ST_WALK_CHK: begin
					state_q <= (dr_q == '0) ? ST_FIN_D : ST_LF_RD;
				end

				// LF step: symbol of the current row
				ST_LF_RD: begin
					if (cur_q == {2'b00, sentinel_q}) begin
						cur_q   <= '0;
						steps_q <= steps_q + ROW_W'(1);
						state_q <= ST_STEP_CHK;
					end else begin
						state_q <= ST_LF_C;
					end
				end

				ST_LF_C: begin
					rc_q      <= (cur_q < CUR_W'(TEXT_MAX)) ? bwt_rdata : 1'b0;
					phi_q     <= cur_lim;
					plo_q     <= cur_lim;
					r_q       <= '0;
					cnt_q     <= '0;
					rank_lf_q <= 1'b1;
					state_q   <= ST_RSWEEP_A;
				end

				// walk length guard
				ST_STEP_CHK: begin
					if (steps_q > n_eff) begin
						res_pos_q    <= '0;
						res_last_q   <= loc_last;
						res_status_q <= STAT_WALK;
						next_row_q   <= row_inc;
						state_q      <= ST_EMIT;
					end else begin
						dq_q    <= cur_q;
						dr_q    <= '0;
						dcnt_q  <= '0;
						state_q <= ST_WALK_DIV;
					end
				end

				// sampled position plus steps, modulo length
				ST_FIN_D: begin
					if (n_eff == '0) begin
						res_pos_q    <= '0;
						res_last_q   <= loc_last;
						res_status_q <= STAT_OK;
						next_row_q   <= row_inc;
						state_q      <= ST_EMIT;
					end else begin
						dq_q    <= fin_sum;
						dr_q    <= '0;
						dcnt_q  <= '0;
						state_q <= ST_FIN_DIV;
					end
				end

				ST_FIN_DIV: begin
					dq_q   <= div_q_nx;
					dr_q   <= div_r_nx;
					dcnt_q <= dcnt_q + 4'd1;
					if (dcnt_q == 4'(CUR_W - 1)) begin
						res_pos_q    <= div_r_nx[ADDR_W-1:0];
						res_last_q   <= loc_last;
						res_status_q <= STAT_OK;
						next_row_q   <= row_inc;
						state_q      <= ST_EMIT;
					end
				end

				// hand the result to the output register
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (emit_go) begin
			result_kind    <= res_kind_q;
			match_count    <= res_count_q;
			interval_start <= res_start_q;
			text_position  <= res_pos_q;
			last_position  <= res_last_q;
			status         <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		range_low_q <= range_high_q)
		else $error("interval low bound above high bound");

	a_sweep_back: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RSWEEP_D |=> state_q == ST_RSWEEP_A)
		else $error("rank sweep count phase did not return");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LF_RD |-> steps_q <= n_eff)
		else $error("LF walk ran past the length guard");

endmodule

### rtl/fmbs_ram.sv
// ----------------------------------------------------------------------------
// fmbs_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fmbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
